### rtl/rxff_pkg.sv
// shared constants and types for the uart receive fifo with xon/xoff flow control
// no dependencies; used by rxff_mem, rxff_ctrl and rx_fifo_xon_xoff_core
`default_nettype none

package rxff_pkg;

    // default ring depth
    localparam int DEPTH_DEFAULT = 8;

    // flow-control characters
    localparam logic [7:0] XON_CHAR  = 8'h11;
    localparam logic [7:0] XOFF_CHAR = 8'h13;

    // configuration registers
    localparam int THRESH_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ENABLE     = 1'd1;
    localparam logic [THRESH_W-1:0]  THRESH_RESET        = 3'd3;
    localparam logic                 FLOW_EN_RESET       = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // result flags of one item, handed from the control stage to the output stage
    typedef struct packed {
        logic       read_valid;
        logic       flow_valid;
        logic [7:0] flow_char;
    } result_t;

endpackage

`default_nettype wire

### rtl/rx_fifo_xon_xoff_core.sv
// Receive ring buffer of a UART with XON/XOFF flow control. Every item on the
// slave side is either a received byte (tuser 0) or a read request (tuser 1) and
// gives exactly one item on the master side. A new item can be taken every clock
// cycle while the master side keeps up: the next head and tail pointers are computed
// combinationally from the head and tail registers, and the byte store is read
// through its one registered port. The result passes through the first stage register
// and then the output register before it is on the master side; while a result waits
// for m_tready, the first stage takes one more item and then holds s_tready low. The
// store has no reset and needs no clearing pass; only written entries are read.
// Depends on rxff_pkg, rxff_ctrl and rxff_mem.
`default_nettype none

module rx_fifo_xon_xoff_core #(
    parameter int DEPTH = rxff_pkg::DEPTH_DEFAULT
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // config writes
    input  wire                              cfg_we,
    input  wire [rxff_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [rxff_pkg::THRESH_W-1:0]     cfg_wdata,
    // input items
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // rx_byte[7:0], overrun_error[8], framing_error[9], zero fill
    input  wire [rxff_pkg::S_TDATA_W-1:0]    s_tdata,
    // command[0]
    input  wire                              s_tuser,
    // result items
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // read_valid[0], read_byte[8:1], flow_valid[9], flow_char[17:10], zero fill
    output logic [rxff_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [rxff_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic              out_free;
    logic              st1_pop;
    logic              st1_valid;
    rxff_pkg::result_t st1_result;
    logic [7:0]        st1_rd_data;
    logic [7:0]        read_byte;

    assign out_free = !m_tvalid_reg || m_tready;
    assign st1_pop  = st1_valid && out_free;

    rxff_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_command  (s_tuser),
        .in_rx_byte  (s_tdata[7:0]),
        .in_overrun  (s_tdata[8]),
        .in_framing  (s_tdata[9]),
        .st1_pop     (st1_pop),
        .st1_valid   (st1_valid),
        .st1_result  (st1_result),
        .st1_rd_data (st1_rd_data)
    );

    // read byte reads as zero when no byte was returned
    assign read_byte = st1_result.read_valid ? st1_rd_data : 8'h00;

    // pack the result item
    assign m_tdata_next = {6'b0, st1_result.flow_char, st1_result.flow_valid,
                           read_byte, st1_result.read_valid};

    // output register occupancy
    always_comb begin
        if (st1_pop) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_pop) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("result changed while stalled");

    // read byte is zero whenever no byte was returned
    a_read_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tdata_reg[0] |-> (m_tdata_reg[8:1] == 8'h00))
        else $error("read byte set without read valid");

    // flow char is zero whenever no flow request was made
    a_flow_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tdata_reg[9] |-> (m_tdata_reg[17:10] == 8'h00))
        else $error("flow char set without flow valid");

endmodule

`default_nettype wire

### rtl/rxff_mem.sv
// byte store of the receive ring: one write port, one registered read port
// depends on rxff_pkg for the default depth
`default_nettype none

module rxff_mem #(
    parameter int DEPTH = rxff_pkg::DEPTH_DEFAULT
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire [7:0]                 wr_data,
    input  wire                       rd_en,
    input  wire [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [7:0]                rd_data
);

    logic [7:0] store_reg [DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    // registered read, held between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/rxff_ctrl.sv
// pointer control, flow-control decision, config registers and the first result stage
// depends on rxff_pkg and rxff_mem
`default_nettype none

module rxff_ctrl #(
    parameter int DEPTH = rxff_pkg::DEPTH_DEFAULT
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // config writes
    input  wire                              cfg_we,
    input  wire [rxff_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [rxff_pkg::THRESH_W-1:0]     cfg_wdata,
    // incoming item
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              in_command,
    input  wire [7:0]                        in_rx_byte,
    input  wire                              in_overrun,
    input  wire                              in_framing,
    // first result stage
    input  wire                              st1_pop,
    output logic                             st1_valid,
    output rxff_pkg::result_t                st1_result,
    output logic [7:0]                       st1_rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W+1)'(DEPTH);

    logic [PTR_W-1:0]             wp_reg, wp_next;
    logic [PTR_W-1:0]             rp_reg, rp_next;
    logic [rxff_pkg::THRESH_W-1:0] thresh_reg;
    logic                         flow_en_reg;
    logic                         st1_valid_reg, st1_valid_next;
    rxff_pkg::result_t            st1_reg, st1_next;

    logic             accept;
    logic             wr_ok;
    logic             rd_ok;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic [PTR_W:0]   space_raw;
    logic [PTR_W:0]   space;
    logic             xoff_req;
    logic             xon_req;

    // a new item may enter whenever the first stage is empty or drains this cycle
    assign in_ready = !st1_valid_reg || st1_pop;
    assign accept   = in_valid && in_ready;
    assign wr_ok    = accept && !in_command && !(in_overrun || in_framing);
    assign rd_ok    = accept && in_command && (wp_reg != rp_reg);

    // pointer increments with wrap at the ring depth
    assign wp_inc = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;

    // free space after the write, (rp - wp_inc - 1) mod depth
    assign space_raw = {1'b0, rp_reg} + DEPTH_X - {1'b0, wp_inc} - 1'b1;
    assign space     = (space_raw >= DEPTH_X) ? space_raw - DEPTH_X : space_raw;

    assign xoff_req = flow_en_reg && (space <= (PTR_W+1)'(thresh_reg));
    assign xon_req  = flow_en_reg && (wp_reg == rp_inc);

    // next pointers and the result flags of the accepted item
    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        st1_next = '0;
        if (wr_ok) begin
            wp_next = wp_inc;
            // ring caught up with the tail: drop the oldest byte
            if (wp_inc == rp_reg) begin
                rp_next = rp_inc;
            end
            if (xoff_req) begin
                st1_next.flow_valid = 1'b1;
                st1_next.flow_char  = rxff_pkg::XOFF_CHAR;
            end
        end else if (rd_ok) begin
            rp_next = rp_inc;
            st1_next.read_valid = 1'b1;
            if (xon_req) begin
                st1_next.flow_valid = 1'b1;
                st1_next.flow_char  = rxff_pkg::XON_CHAR;
            end
        end
    end

    // first stage occupancy
    always_comb begin
        if (accept) begin
            st1_valid_next = 1'b1;
        end else if (st1_pop) begin
            st1_valid_next = 1'b0;
        end else begin
            st1_valid_next = st1_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            st1_valid_reg <= st1_valid_next;
        end
    end

    // result flags, loaded with each accepted item
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg <= st1_next;
        end
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg  <= rxff_pkg::THRESH_RESET;
            flow_en_reg <= rxff_pkg::FLOW_EN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                rxff_pkg::CFG_SPARE_THRESHOLD: thresh_reg  <= cfg_wdata;
                rxff_pkg::CFG_FLOW_ENABLE:     flow_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // byte store
    rxff_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_ok),
        .wr_addr (wp_reg),
        .wr_data (in_rx_byte),
        .rd_en   (rd_ok),
        .rd_addr (rp_reg),
        .rd_data (st1_rd_data)
    );

    assign st1_valid  = st1_valid_reg;
    assign st1_result = st1_reg;

    // a stored good byte always leaves the ring non-empty
    a_not_empty_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ok |=> (wp_reg != rp_reg))
        else $error("ring empty after a good write");

    // pointers stay inside the ring
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg <= PTR_LAST) && (rp_reg <= PTR_LAST))
        else $error("pointer out of range");

    // a read can only come with an xon, never an xoff
    a_read_flow_char: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && st1_reg.read_valid && st1_reg.flow_valid
            |-> (st1_reg.flow_char == rxff_pkg::XON_CHAR))
        else $error("xoff reported with a read");

    // a stalled result keeps its flags
    a_st1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !st1_pop |=> st1_valid_reg && $stable(st1_reg))
        else $error("first stage changed while stalled");

endmodule

`default_nettype wire

### bench/rxff_tb_pkg.sv
// item codes and the result layout shared by the fifo testbench and its checker
// no dependencies; used by rxff_flow_checker and tb_rx_fifo_xon_xoff_core
`default_nettype none

package rxff_tb_pkg;

    // what an input item asks for, carried on s_tuser
    typedef enum logic {
        CMD_RX   = 1'b0,
        CMD_READ = 1'b1
    } cmd_e;

    // one result item as unpacked from m_tdata
    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_byte;
        logic       flow_valid;
        logic [7:0] flow_char;
    } rx_result_t;

endpackage

`default_nettype wire

### bench/rxff_flow_checker.sv
// watches both streams and the register port of rx_fifo_xon_xoff_core, predicts
// every result with its own ring buffer copy and compares it field by field
// depends on rxff_pkg and rxff_tb_pkg; instantiated by tb_rx_fifo_xon_xoff_core
`default_nettype none

module rxff_flow_checker
    import rxff_pkg::*;
    import rxff_tb_pkg::*;
(
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      cfg_we,
    input  wire [CFG_IDX_W-1:0]      cfg_index,
    input  wire [THRESH_W-1:0]       cfg_wdata,
    input  wire                      s_tvalid,
    input  wire                      s_tready,
    // rx_byte[7:0], overrun_error[8], framing_error[9], zero fill
    input  wire [S_TDATA_W-1:0]      s_tdata,
    // command[0]
    input  wire                      s_tuser,
    input  wire                      m_tvalid,
    input  wire                      m_tready,
    // read_valid[0], read_byte[8:1], flow_valid[9], flow_char[17:10], zero fill
    input  wire [M_TDATA_W-1:0]      m_tdata,
    output int                       n_errors,
    output int                       n_pending,
    output int                       n_results,
    output int                       n_bytes_read,
    output int                       n_empty_reads,
    output int                       n_dropped,
    output int                       n_overflow,
    output int                       n_xoff,
    output int                       n_xon
);

    localparam int PTR_W     = $clog2(DEPTH_DEFAULT);
    localparam int MAX_LINES = 40;

    // predicted buffer contents, pointers and register copies
    logic [7:0]          ring [DEPTH_DEFAULT];
    logic [PTR_W-1:0]    head;
    logic [PTR_W-1:0]    tail;
    logic [THRESH_W-1:0] spare_thresh;
    logic                flow_on;
    rx_result_t          due_results [$];

    // one line per mismatch, printing capped so a broken block cannot flood the log
    task automatic report(input string msg);
        n_errors++;
        if (n_errors <= MAX_LINES)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // applies one item to the predicted ring and returns the result it owes
    function automatic rx_result_t advance_ring(input cmd_e cmd, input logic [7:0] data,
                                                input logic bad);
        rx_result_t       r;
        logic [PTR_W-1:0] free_slots;
        r = '0;
        if (cmd == CMD_RX) begin
            if (bad) begin
                n_dropped++;
            end else begin
                ring[head] = data;
                head = head + 1'b1;
                free_slots = tail - head - 1'b1;
                if (flow_on && free_slots <= spare_thresh) begin
                    r.flow_valid = 1'b1;
                    r.flow_char  = XOFF_CHAR;
                    n_xoff++;
                end
                // head caught the tail: oldest byte is lost
                if (head == tail) begin
                    tail = tail + 1'b1;
                    n_overflow++;
                end
            end
        end else if (head != tail) begin
            r.read_valid = 1'b1;
            r.read_byte  = ring[tail];
            tail = tail + 1'b1;
            n_bytes_read++;
            if (flow_on && head == tail) begin
                r.flow_valid = 1'b1;
                r.flow_char  = XON_CHAR;
                n_xon++;
            end
        end else begin
            n_empty_reads++;
        end
        return r;
    endfunction

    // results are compared before the item of the same edge is predicted
    always @(posedge aclk) begin
        rx_result_t got;
        rx_result_t want;
        if (!aresetn) begin
            head         = '0;
            tail         = '0;
            spare_thresh = THRESH_RESET;
            flow_on      = FLOW_EN_RESET;
            due_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_SPARE_THRESHOLD)
                    spare_thresh = cfg_wdata;
                else if (cfg_index == CFG_FLOW_ENABLE)
                    flow_on = cfg_wdata[0];
            end
            if (m_tvalid && m_tready) begin
                got.read_valid = m_tdata[0];
                got.read_byte  = m_tdata[8:1];
                got.flow_valid = m_tdata[9];
                got.flow_char  = m_tdata[17:10];
                n_results++;
                if (due_results.size() == 0) begin
                    report($sformatf("result %0d arrived with nothing outstanding", n_results));
                end else begin
                    want = due_results.pop_front();
                    if (got.read_valid !== want.read_valid)
                        report($sformatf("result %0d read_valid %b, expected %b",
                                         n_results, got.read_valid, want.read_valid));
                    if (got.read_byte !== want.read_byte)
                        report($sformatf("result %0d read_byte %h, expected %h",
                                         n_results, got.read_byte, want.read_byte));
                    if (got.flow_valid !== want.flow_valid)
                        report($sformatf("result %0d flow_valid %b, expected %b",
                                         n_results, got.flow_valid, want.flow_valid));
                    if (got.flow_char !== want.flow_char)
                        report($sformatf("result %0d flow_char %h, expected %h",
                                         n_results, got.flow_char, want.flow_char));
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(advance_ring(cmd_e'(s_tuser), s_tdata[7:0],
                                                   s_tdata[8] | s_tdata[9]));
        end
        n_pending = due_results.size();
    end

endmodule

`default_nettype wire

### bench/tb_rx_fifo_xon_xoff_core.sv
// top of the rx_fifo_xon_xoff_core testbench: clock, reset, stimulus and verdict
// depends on rxff_pkg, rxff_tb_pkg, rxff_flow_checker and the block itself
`default_nettype none

module tb_rx_fifo_xon_xoff_core;
    import rxff_pkg::*;
    import rxff_tb_pkg::*;

    localparam int STALL_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 180;
    localparam int N_PHASES       = 6;

    // how a burst of random items leans between writes and reads
    typedef enum int {
        LEAN_FILL,
        LEAN_DRAIN,
        LEAN_EVEN
    } lean_e;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THRESH_W-1:0]  cfg_wdata;
    logic                 s_tvalid;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tready;
    wire                  s_tready;
    wire                  m_tvalid;
    wire [M_TDATA_W-1:0]  m_tdata;

    logic s_fire       = 1'b0;
    bit   no_idle      = 1'b0;
    bit   stall_req    = 1'b0;
    bit   stall_active = 1'b0;
    bit   stall_done   = 1'b0;
    int   quiet_cycles = 0;
    int   items_sent   = 0;

    int n_errors, n_pending, n_results, n_bytes_read, n_empty_reads;
    int n_dropped, n_overflow, n_xoff, n_xon;

    rx_fifo_xon_xoff_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rxff_flow_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .n_errors      (n_errors),
        .n_pending     (n_pending),
        .n_results     (n_results),
        .n_bytes_read  (n_bytes_read),
        .n_empty_reads (n_empty_reads),
        .n_dropped     (n_dropped),
        .n_overflow    (n_overflow),
        .n_xoff        (n_xoff),
        .n_xon         (n_xon)
    );

    // 10 unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // input handshake seen at the edge, read back at the following falling edge
    always @(posedge aclk) begin
        s_fire <= s_tvalid && s_tready;
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer", quiet_cycles);
            $display("rx_fifo_xon_xoff_core verification failed");
            $finish;
        end
    end

    // result side: one long hold-off on request, random stall bursts otherwise
    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (stall_req && !stall_done) begin
                stall_active = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
                stall_active = 1'b0;
                stall_done   = 1'b1;
            end else if (!no_idle && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // offers one item, maybe after a gap, and returns at the falling edge after it is taken
    task automatic push_item(input cmd_e cmd, input logic [7:0] data,
                             input logic ovr, input logic frm);
        if (!no_idle && !stall_active && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({frm, ovr, data});
        do @(negedge aclk); while (!s_fire);
        items_sent++;
    endtask

    task automatic random_item(input lean_e lean);
        int   pct_rx;
        cmd_e cmd;
        case (lean)
            LEAN_FILL:  pct_rx = 80;
            LEAN_DRAIN: pct_rx = 20;
            default:    pct_rx = 50;
        endcase
        cmd = ($urandom_range(0, 99) < pct_rx) ? CMD_RX : CMD_READ;
        push_item(cmd, 8'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [THRESH_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // drain the block, then change threshold and flow enable
    task automatic set_flow(input logic [THRESH_W-1:0] thresh, input logic enable);
        s_tvalid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_write(CFG_SPARE_THRESHOLD, thresh);
        cfg_write(CFG_FLOW_ENABLE, THRESH_W'(enable));
    endtask

    initial begin
        logic [THRESH_W-1:0] thr_plan [N_PHASES] = '{3'd0, 3'd7, 3'd5, 3'd2, 3'd6, 3'd3};
        logic                en_plan  [N_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        logic [7:0]          fill_bytes [8] =
            '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
        int                  burst_left;
        lean_e               lean;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        burst_left = 0;
        lean       = LEAN_EVEN;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty read with junk fields, errored bytes, fill past full, drain
        push_item(CMD_READ, 8'hA5, 1'b1, 1'b1);
        push_item(CMD_RX, 8'hFF, 1'b1, 1'b0);
        push_item(CMD_RX, 8'h00, 1'b0, 1'b1);
        push_item(CMD_RX, 8'h5A, 1'b1, 1'b1);
        for (int i = 0; i < 8; i++)
            push_item(CMD_RX, fill_bytes[i], 1'b0, 1'b0);
        for (int i = 0; i < 7; i++)
            push_item(CMD_READ, ~fill_bytes[i], i[0], i[1]);
        push_item(CMD_READ, 8'h00, 1'b0, 1'b0);

        // random phases, each under its own threshold and flow setting
        for (int p = 0; p < N_PHASES; p++) begin
            set_flow(thr_plan[p], en_plan[p]);
            if (p == 0)
                stall_req = 1'b1;
            if (p == N_PHASES - 1)
                no_idle = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (burst_left == 0) begin
                    lean       = lean_e'($urandom_range(0, 2));
                    burst_left = $urandom_range(4, 24);
                end
                burst_left--;
                random_item(lean);
            end
        end

        // let every outstanding result come back
        s_tvalid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("covered %0d items and %0d results: %0d bytes read, %0d empty reads,",
                 items_sent, n_results, n_bytes_read, n_empty_reads);
        $display("%0d errored bytes dropped, %0d xoff, %0d xon, %0d overflows; %s",
                 n_dropped, n_xoff, n_xon, n_overflow,
                 "thresholds 0 to 7, flow on and off");
        if (n_errors == 0 && n_pending == 0) begin
            $display("rx_fifo_xon_xoff_core verification clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", n_errors, n_pending);
            $display("rx_fifo_xon_xoff_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
